/* hdl/aare_pkg.sv */
package aare_pkg;

  localparam int unsigned RegIdxW = 3;
  localparam logic [RegIdxW-1:0] RegA = 3'd7;

  localparam logic [7:0] OpNop = 8'h00;
  localparam logic [7:0] OpHlt = 8'h76;
  localparam logic [7:0] OpOut = 8'hD3;

  localparam logic [1:0] GrpLow = 2'b00;
  localparam logic [1:0] GrpMov = 2'b01;
  localparam logic [1:0] GrpAlu = 2'b10;
  localparam logic [1:0] GrpHigh = 2'b11;

  localparam logic [2:0] SrcInr = 3'd4;
  localparam logic [2:0] SrcDcr = 3'd5;
  localparam logic [2:0] SrcImm = 3'd6;

  // flag byte layout SZ0A0P1C
  localparam logic [7:0] FlagReset = 8'h02;
  localparam int unsigned FlagBitS = 7;
  localparam int unsigned FlagBitZ = 6;
  localparam int unsigned FlagBitAc = 4;
  localparam int unsigned FlagBitP = 2;
  localparam int unsigned FlagBitOne = 1;
  localparam int unsigned FlagBitCy = 0;

  typedef enum logic [2:0] {
    K_NOP,
    K_HLT,
    K_MOV,
    K_ALU,
    K_MVI,
    K_INC,
    K_OUT,
    K_BAD
  } kind_e;

  typedef enum logic [3:0] {
    M_ADD = 4'd0,
    M_ADC = 4'd1,
    M_SUB = 4'd2,
    M_SBB = 4'd3,
    M_ANA = 4'd4,
    M_XRA = 4'd5,
    M_ORA = 4'd6,
    M_CMP = 4'd7,
    M_INR = 4'd8,
    M_DCR = 4'd9
  } alu_mode_e;

  typedef struct packed {
    kind_e              kind;
    alu_mode_e          mode;
    logic [RegIdxW-1:0] dst;
    logic [RegIdxW-1:0] src;
    logic               use_imm;
    logic [1:0]         len;
  } dec_t;

endpackage

/* hdl/aare_decode.sv */
module aare_decode (
  input  logic [7:0]      opcode_i,
  output aare_pkg::dec_t  dec_o
);
  import aare_pkg::*;

  logic [1:0] grp;

  assign grp = opcode_i[7:6];

  always_comb begin
    dec_o         = '0;
    dec_o.kind    = K_BAD;
    dec_o.mode    = alu_mode_e'({1'b0, opcode_i[5:3]});
    dec_o.dst     = opcode_i[5:3];
    dec_o.src     = opcode_i[2:0];
    dec_o.use_imm = 1'b0;
    dec_o.len     = 2'd0;
    unique case (grp)
      GrpMov: begin
        // HLT takes the slot of MOV M,M
        if (opcode_i == OpHlt) begin
          dec_o.kind = K_HLT;
        end else begin
          dec_o.kind = K_MOV;
        end
        dec_o.len = 2'd1;
      end
      GrpAlu: begin
        dec_o.kind = K_ALU;
        dec_o.len  = 2'd1;
      end
      GrpLow: begin
        if (opcode_i == OpNop) begin
          dec_o.kind = K_NOP;
          dec_o.len  = 2'd1;
        end else if (opcode_i[2:0] == SrcImm) begin
          dec_o.kind = K_MVI;
          dec_o.len  = 2'd2;
        end else if (opcode_i[2:0] == SrcInr) begin
          dec_o.kind = K_INC;
          dec_o.mode = M_INR;
          dec_o.len  = 2'd1;
        end else if (opcode_i[2:0] == SrcDcr) begin
          dec_o.kind = K_INC;
          dec_o.mode = M_DCR;
          dec_o.len  = 2'd1;
        end
      end
      GrpHigh: begin
        if (opcode_i == OpOut) begin
          dec_o.kind = K_OUT;
          dec_o.len  = 2'd2;
        end else if (opcode_i[2:0] == SrcImm) begin
          dec_o.kind    = K_ALU;
          dec_o.use_imm = 1'b1;
          dec_o.len     = 2'd2;
        end
      end
      default: dec_o.kind = K_BAD;
    endcase
  end

endmodule

/* hdl/aare_alu.sv */
module aare_alu (
  input  aare_pkg::alu_mode_e mode_i,
  input  logic [7:0]          a_i,
  input  logic [7:0]          b_i,
  input  logic                cy_i,
  output logic [7:0]          res_o,
  output logic [7:0]          flags_o
);
  import aare_pkg::*;

  logic       cin;
  logic [8:0] sum;
  logic [8:0] diff;
  logic [4:0] nsum;
  logic [4:0] ndiff;
  logic       cy;
  logic       ac;

  assign cin = ((mode_i == M_ADC) || (mode_i == M_SBB)) ? cy_i : 1'b0;

  assign sum   = {1'b0, a_i} + {1'b0, b_i} + {8'b0, cin};
  assign diff  = {1'b0, a_i} - {1'b0, b_i} - {8'b0, cin};
  assign nsum  = {1'b0, a_i[3:0]} + {1'b0, b_i[3:0]} + {4'b0, cin};
  // bit 4 set means the low nibble borrowed
  assign ndiff = {1'b0, a_i[3:0]} - {1'b0, b_i[3:0]} - {4'b0, cin};

  always_comb begin
    res_o = a_i;
    cy    = 1'b0;
    ac    = 1'b0;
    case (mode_i)
      M_ADD, M_ADC: begin
        res_o = sum[7:0];
        cy    = sum[8];
        ac    = nsum[4];
      end
      M_SUB, M_SBB, M_CMP: begin
        res_o = diff[7:0];
        cy    = diff[8];
        ac    = ndiff[4];
      end
      M_ANA: begin
        res_o = a_i & b_i;
        ac    = 1'b1;
      end
      M_XRA: res_o = a_i ^ b_i;
      M_ORA: res_o = a_i | b_i;
      // INR/DCR work on b_i and keep carry
      M_INR: begin
        res_o = b_i + 8'd1;
        cy    = cy_i;
        ac    = (b_i[3:0] == 4'hF);
      end
      M_DCR: begin
        res_o = b_i - 8'd1;
        cy    = cy_i;
        ac    = (b_i[3:0] == 4'h0);
      end
      default: res_o = a_i;
    endcase
  end

  always_comb begin
    flags_o             = '0;
    flags_o[FlagBitS]   = res_o[7];
    flags_o[FlagBitZ]   = (res_o == 8'h00);
    flags_o[FlagBitAc]  = ac;
    flags_o[FlagBitP]   = ~^res_o;
    flags_o[FlagBitOne] = 1'b1;
    flags_o[FlagBitCy]  = cy;
  end

endmodule

/* hdl/accumulator_alu_register_execute_core.sv */
// Accumulator ALU register-execute core.
// Input channel (in_valid_i/in_ready_o) takes one instruction word per
// handshake: opcode_byte_i and immediate_byte_i. Output channel
// (out_valid_o/out_ready_i) returns one result word per instruction:
// accumulator and flags after it, instruction length, an OUT port write
// event, and the halted/bad-opcode status.
// The input handshake loads the input register; the execute stage then
// writes state and the result register once the result register is free.
// Throughput: 1 instruction per cycle while the receiver does not stall;
// the register file and flags update in the execute stage, so the next
// instruction sees them with no bubble.
// Reset clears registers B..A to zero, flags to 0x02 and starts running.
// After HLT or an undefined opcode every later word reports halted with
// length 0 and leaves the state untouched.
// When the receiver stalls, the result register holds; the input register
// takes one more word, keeps it, and in_ready_o stays low until the output
// moves again.
module accumulator_alu_register_execute_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] opcode_byte_i,
  input  logic [7:0] immediate_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] accumulator_o,
  output logic [7:0] flag_byte_o,
  output logic [1:0] insn_length_o,
  output logic       port_write_o,
  output logic [7:0] port_addr_o,
  output logic [7:0] port_data_o,
  output logic       halted_o,
  output logic       bad_opcode_o
);
  import aare_pkg::*;

  // input register
  logic       iv_q;
  logic [7:0] op_q, imm_q;

  // architectural state
  logic [7:0] regs_q [8];
  logic [7:0] regs_d [8];
  logic [7:0] flags_q, flags_d;
  logic       run_q, run_d;

  // result register
  logic       ov_q;
  logic [7:0] acc_q, acc_d, flg_q, pn_q, pn_d, pd_q, pd_d;
  logic [1:0] len_q, len_d;
  logic       pw_q, pw_d, halt_q, bad_q, bad_d;

  logic               fire;
  dec_t               dec;
  logic [RegIdxW-1:0] rd_idx;
  logic [7:0]         rd_val;
  logic [7:0]         operand;
  logic [7:0]         alu_res, alu_flags;

  assign fire       = iv_q && (!ov_q || out_ready_i);
  assign in_ready_o = !iv_q || fire;

  aare_decode u_dec (
    .opcode_i (op_q),
    .dec_o    (dec)
  );

  // one indexed data read port (A is read directly): INR/DCR read dst, everything else src
  assign rd_idx  = (dec.kind == K_INC) ? dec.dst : dec.src;
  assign rd_val  = regs_q[rd_idx];
  assign operand = dec.use_imm ? imm_q : rd_val;

  aare_alu u_alu (
    .mode_i  (dec.mode),
    .a_i     (regs_q[RegA]),
    .b_i     (operand),
    .cy_i    (flags_q[FlagBitCy]),
    .res_o   (alu_res),
    .flags_o (alu_flags)
  );

  always_comb begin
    regs_d  = regs_q;
    flags_d = flags_q;
    run_d   = run_q;
    len_d   = 2'd0;
    pw_d    = 1'b0;
    pn_d    = 8'h00;
    pd_d    = 8'h00;
    bad_d   = 1'b0;
    if (run_q) begin
      len_d = dec.len;
      unique case (dec.kind)
        K_NOP: ;
        K_HLT: run_d = 1'b0;
        K_MOV: regs_d[dec.dst] = rd_val;
        K_MVI: regs_d[dec.dst] = imm_q;
        K_INC: begin
          regs_d[dec.dst] = alu_res;
          flags_d         = alu_flags;
        end
        K_ALU: begin
          flags_d = alu_flags;
          if (dec.mode != M_CMP) begin
            regs_d[RegA] = alu_res;
          end
        end
        K_OUT: begin
          pw_d = 1'b1;
          pn_d = imm_q;
          pd_d = regs_q[RegA];
        end
        K_BAD: begin
          run_d = 1'b0;
          bad_d = 1'b1;
        end
        default: ;
      endcase
    end
    acc_d = regs_d[RegA];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (in_ready_o) begin
      iv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q  <= opcode_byte_i;
      imm_q <= immediate_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        regs_q[i] <= 8'h00;
      end
      flags_q <= FlagReset;
      run_q   <= 1'b1;
    end else if (fire) begin
      regs_q  <= regs_d;
      flags_q <= flags_d;
      run_q   <= run_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (fire) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      acc_q  <= acc_d;
      flg_q  <= flags_d;
      len_q  <= len_d;
      pw_q   <= pw_d;
      pn_q   <= pn_d;
      pd_q   <= pd_d;
      halt_q <= !run_d;
      bad_q  <= bad_d;
    end
  end

  assign out_valid_o   = ov_q;
  assign accumulator_o = acc_q;
  assign flag_byte_o   = flg_q;
  assign insn_length_o = len_q;
  assign port_write_o  = pw_q;
  assign port_addr_o   = pn_q;
  assign port_data_o   = pd_q;
  assign halted_o      = halt_q;
  assign bad_opcode_o  = bad_q;

endmodule

/* hdl/aare_checker.sv */
module aare_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] accumulator_o,
  input logic [7:0] flag_byte_o,
  input logic [1:0] insn_length_o,
  input logic       port_write_o,
  input logic [7:0] port_addr_o,
  input logic [7:0] port_data_o,
  input logic       halted_o,
  input logic       bad_opcode_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(accumulator_o))
    else $error("result word dropped or changed while stalled");

  a_bad_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_opcode_o |-> halted_o && (insn_length_o == 2'd0))
    else $error("bad opcode without halt");

  a_port_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !port_write_o |-> (port_addr_o == 8'h00) && (port_data_o == 8'h00))
    else $error("port fields set without OUT");

  a_port_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && port_write_o |-> (port_data_o == accumulator_o) && (insn_length_o == 2'd2))
    else $error("OUT data differs from accumulator");

  a_flag_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> flag_byte_o[1] && !flag_byte_o[3] && !flag_byte_o[5])
    else $error("fixed flag bits wrong");

endmodule

bind accumulator_alu_register_execute_core aare_checker u_aare_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .accumulator_o (accumulator_o),
  .flag_byte_o   (flag_byte_o),
  .insn_length_o (insn_length_o),
  .port_write_o  (port_write_o),
  .port_addr_o   (port_addr_o),
  .port_data_o   (port_data_o),
  .halted_o      (halted_o),
  .bad_opcode_o  (bad_opcode_o)
);

/* tb/sv/tb_accumulator_alu_register_execute_core.sv */
`timescale 1ns / 1ps

module tb_accumulator_alu_register_execute_core;
  import aare_pkg::*;

  localparam int unsigned IdleLimit = 1000;
  localparam int unsigned RandomWords = 1600;
  localparam int unsigned StoppedWords = 40;
  localparam int unsigned HoldAt = 1200;
  localparam int unsigned HoldLen = 80;

  localparam logic [RegIdxW-1:0] RegB = 3'd0;
  localparam logic [RegIdxW-1:0] RegC = 3'd1;
  localparam logic [RegIdxW-1:0] RegD = 3'd2;
  localparam logic [RegIdxW-1:0] RegE = 3'd3;
  localparam logic [RegIdxW-1:0] RegH = 3'd4;
  localparam logic [RegIdxW-1:0] RegL = 3'd5;
  localparam logic [RegIdxW-1:0] RegM = 3'd6;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_HALF,
    RX_SPARSE,
    RX_TOGGLE
  } rx_mode_e;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] imm;
  } insn_word_t;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] flags;
    logic [1:0] len;
    logic       pw;
    logic [7:0] port;
    logic [7:0] pdata;
    logic       halted;
    logic       bad;
  } insn_result_t;

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] opcode = 8'h00;
  logic [7:0] imm = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] acc_o;
  logic [7:0] flags_o;
  logic [1:0] len_o;
  logic       pw_o;
  logic [7:0] port_o;
  logic [7:0] pdata_o;
  logic       halted_o;
  logic       bad_o;

  insn_word_t   insn_words_q[$];
  insn_result_t insn_results_q[$];
  insn_word_t   cur_word;
  insn_result_t got_res;
  insn_result_t want_res;

  // predictor state
  logic [7:0] gpr[8];
  logic [7:0] flag_q;
  logic       running_q;

  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  int unsigned idle_cycles = 0;
  rx_mode_e    rx_mode = RX_ALWAYS;

  accumulator_alu_register_execute_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .opcode_byte_i   (opcode),
    .immediate_byte_i(imm),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .accumulator_o   (acc_o),
    .flag_byte_o     (flags_o),
    .insn_length_o   (len_o),
    .port_write_o    (pw_o),
    .port_addr_o     (port_o),
    .port_data_o     (pdata_o),
    .halted_o        (halted_o),
    .bad_opcode_o    (bad_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] szp_bits(input logic [7:0] v);
    logic [7:0] f;
    f = '0;
    f[FlagBitS] = v[7];
    f[FlagBitZ] = (v == 8'h00);
    f[FlagBitP] = ~^v;
    return f;
  endfunction

  function automatic void alu_update(input alu_mode_e mode, input logic [7:0] b);
    logic [7:0] a;
    logic [7:0] r;
    logic [7:0] f;
    logic [8:0] sum;
    logic       c;
    a = gpr[RegA];
    c = (mode == M_ADC || mode == M_SBB) ? flag_q[FlagBitCy] : 1'b0;
    f = '0;
    f[FlagBitOne] = 1'b1;
    case (mode)
      M_ADD, M_ADC: begin
        sum = {1'b0, a} + {1'b0, b} + c;
        r = sum[7:0];
        f[FlagBitCy] = sum[8];
        f[FlagBitAc] = ({1'b0, a[3:0]} + {1'b0, b[3:0]} + c) > 5'd15;
      end
      M_SUB, M_SBB, M_CMP: begin
        r = a - b - c;
        f[FlagBitCy] = {1'b0, a} < ({1'b0, b} + c);
        f[FlagBitAc] = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + c);
      end
      M_ANA: begin
        r = a & b;
        f[FlagBitAc] = 1'b1;
      end
      M_XRA: r = a ^ b;
      default: r = a | b;
    endcase
    flag_q = f | szp_bits(r);
    if (mode != M_CMP) gpr[RegA] = r;
  endfunction

  function automatic insn_result_t exec_insn(input logic [7:0] op, input logic [7:0] ib);
    insn_result_t res;
    logic [2:0]   dst;
    logic [2:0]   src;
    logic [7:0]   old;
    logic [7:0]   r;
    logic [7:0]   f;
    res = '0;
    dst = op[5:3];
    src = op[2:0];
    if (running_q) begin
      if (op == OpNop) begin
        res.len = 2'd1;
      end else if (op == OpHlt) begin
        running_q = 1'b0;
        res.len = 2'd1;
      end else if (op[7:6] == GrpMov) begin
        gpr[dst] = gpr[src];
        res.len = 2'd1;
      end else if (op[7:6] == GrpAlu) begin
        alu_update(alu_mode_e'({1'b0, dst}), gpr[src]);
        res.len = 2'd1;
      end else if (op[7:6] == GrpLow && src == SrcImm) begin
        gpr[dst] = ib;
        res.len = 2'd2;
      end else if (op[7:6] == GrpLow && (src == SrcInr || src == SrcDcr)) begin
        old = gpr[dst];
        f = '0;
        f[FlagBitOne] = 1'b1;
        f[FlagBitCy] = flag_q[FlagBitCy];
        if (src == SrcInr) begin
          r = old + 8'd1;
          f[FlagBitAc] = (old[3:0] == 4'hF);
        end else begin
          r = old - 8'd1;
          f[FlagBitAc] = (old[3:0] == 4'h0);
        end
        gpr[dst] = r;
        flag_q = f | szp_bits(r);
        res.len = 2'd1;
      end else if (op == OpOut) begin
        res.pw = 1'b1;
        res.port = ib;
        res.pdata = gpr[RegA];
        res.len = 2'd2;
      end else if (op[7:6] == GrpHigh && src == SrcImm) begin
        alu_update(alu_mode_e'({1'b0, dst}), ib);
        res.len = 2'd2;
      end else begin
        res.bad = 1'b1;
        running_q = 1'b0;
      end
    end
    res.acc = gpr[RegA];
    res.flags = flag_q;
    res.halted = ~running_q;
    return res;
  endfunction

  function automatic logic [7:0] op_word(input logic [1:0] grp, input logic [2:0] mid,
                                         input logic [2:0] low);
    return {grp, mid, low};
  endfunction

  function automatic logic [2:0] mode_field(input alu_mode_e m);
    logic [3:0] v;
    v = m;
    return v[2:0];
  endfunction

  // biased toward carry and nibble edges
  function automatic logic [7:0] rand_imm();
    logic [7:0] edges[5];
    edges = '{8'h00, 8'hFF, 8'h0F, 8'h80, 8'h01};
    if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 4)];
    return 8'($urandom_range(0, 255));
  endfunction

  // only opcodes that keep the core running
  function automatic logic [7:0] rand_defined_op();
    logic [2:0] r1;
    logic [2:0] r2;
    r1 = 3'($urandom_range(0, 7));
    r2 = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0: return OpNop;
      1, 2: begin
        // MOV M,M would decode as HLT
        if (r1 == RegM && r2 == RegM) return op_word(GrpMov, RegA, RegM);
        return op_word(GrpMov, r1, r2);
      end
      3, 4, 5: return op_word(GrpAlu, r1, r2);
      6: return op_word(GrpLow, r1, SrcImm);
      7: return op_word(GrpLow, r1, r2[0] ? SrcDcr : SrcInr);
      8: return op_word(GrpHigh, r1, SrcImm);
      default: return OpOut;
    endcase
  endfunction

  task automatic add_word(input logic [7:0] op, input logic [7:0] ib);
    insn_word_t w;
    w.opcode = op;
    w.imm = ib;
    insn_words_q.push_back(w);
  endtask

  task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // sender: bursts of words separated by random gaps
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (insn_words_q.size() != 0) begin
          cur_word = insn_words_q.pop_front();
          burst_left--;
          in_valid <= 1'b1;
          opcode <= cur_word.opcode;
          imm <= cur_word.imm;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern changes now and then, plus one long hold-off
  always @(posedge clk_i) begin
    if (rst_n) begin
      rx_cycle++;
      if (rx_cycle == HoldAt) hold_left = HoldLen;
      if (mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= ~out_ready;
        endcase
      end
    end
  end

  // predict on input handshake, check on output handshake
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && in_ready) insn_results_q.push_back(exec_insn(opcode, imm));
      if (out_valid && out_ready) begin
        if (insn_results_q.size() == 0) begin
          $error("result word with no instruction outstanding");
          mismatches++;
        end else begin
          want_res = insn_results_q.pop_front();
          got_res = '{acc_o, flags_o, len_o, pw_o, port_o, pdata_o, halted_o, bad_o};
          cmp_field("accumulator", want_res.acc, got_res.acc);
          cmp_field("flag_byte", want_res.flags, got_res.flags);
          cmp_field("insn_length", want_res.len, got_res.len);
          cmp_field("port_write", want_res.pw, got_res.pw);
          cmp_field("port_addr", want_res.port, got_res.port);
          cmp_field("port_data", want_res.pdata, got_res.pdata);
          cmp_field("halted", want_res.halted, got_res.halted);
          cmp_field("bad_opcode", want_res.bad, got_res.bad);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned n;
    logic [1:0]  grp;
    logic [2:0]  mid;
    logic [2:0]  low;
    logic [7:0]  stop_op;

    foreach (gpr[i]) gpr[i] = 8'h00;
    flag_q = FlagReset;
    running_q = 1'b1;

    // directed: flag edges on every ALU op, INR/DCR nibble cases, MOV via M, OUT
    add_word(OpNop, rand_imm());
    add_word(op_word(GrpLow, RegA, SrcImm), 8'hFF);
    add_word(op_word(GrpHigh, mode_field(M_ADD), SrcImm), 8'h01);
    add_word(op_word(GrpHigh, mode_field(M_ADC), SrcImm), 8'hFF);
    add_word(op_word(GrpHigh, mode_field(M_SUB), SrcImm), 8'h01);
    add_word(op_word(GrpHigh, mode_field(M_SBB), SrcImm), 8'h00);
    add_word(op_word(GrpHigh, mode_field(M_ANA), SrcImm), 8'h0F);
    add_word(op_word(GrpHigh, mode_field(M_XRA), SrcImm), 8'hFF);
    add_word(op_word(GrpHigh, mode_field(M_ORA), SrcImm), 8'h80);
    add_word(op_word(GrpHigh, mode_field(M_CMP), SrcImm), 8'h80);
    add_word(op_word(GrpLow, RegB, SrcImm), 8'h0F);
    add_word(op_word(GrpLow, RegB, SrcInr), rand_imm());
    add_word(op_word(GrpLow, RegB, SrcDcr), rand_imm());
    add_word(op_word(GrpLow, RegC, SrcImm), 8'h00);
    add_word(op_word(GrpLow, RegC, SrcDcr), rand_imm());
    add_word(op_word(GrpMov, RegM, RegA), rand_imm());
    add_word(op_word(GrpLow, RegA, SrcImm), 8'h55);
    add_word(op_word(GrpMov, RegA, RegM), rand_imm());
    add_word(op_word(GrpAlu, mode_field(M_ADD), RegB), rand_imm());
    add_word(op_word(GrpAlu, mode_field(M_ADC), RegC), rand_imm());
    add_word(op_word(GrpAlu, mode_field(M_SUB), RegD), rand_imm());
    add_word(op_word(GrpAlu, mode_field(M_SBB), RegE), rand_imm());
    add_word(op_word(GrpAlu, mode_field(M_ANA), RegH), rand_imm());
    add_word(op_word(GrpAlu, mode_field(M_XRA), RegL), rand_imm());
    add_word(op_word(GrpAlu, mode_field(M_ORA), RegM), rand_imm());
    add_word(op_word(GrpAlu, mode_field(M_CMP), RegA), rand_imm());
    add_word(OpOut, 8'hFF);
    add_word(op_word(GrpLow, RegA, SrcInr), rand_imm());

    for (n = 0; n < RandomWords; n++) add_word(rand_defined_op(), rand_imm());

    // the core can stop only once per run: pick HLT or an undefined opcode
    if ($urandom_range(0, 1) == 0) begin
      stop_op = OpHlt;
    end else begin
      do begin
        grp = ($urandom_range(0, 1) == 0) ? GrpLow : GrpHigh;
        mid = 3'($urandom_range(0, 7));
        low = 3'($urandom_range(0, 7));
        stop_op = op_word(grp, mid, low);
      end while ((grp == GrpLow && (low == SrcImm || low == SrcInr || low == SrcDcr)) ||
                 (grp == GrpHigh && low == SrcImm) || stop_op == OpNop || stop_op == OpOut);
    end
    add_word(stop_op, rand_imm());

    // everything after the stop must be ignored
    for (n = 0; n < StoppedWords; n++)
      add_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));

    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;

    while (insn_words_q.size() != 0 || in_valid || insn_results_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* accumulator_alu_register_execute_core.f */
hdl/aare_pkg.sv
hdl/aare_decode.sv
hdl/aare_alu.sv
hdl/accumulator_alu_register_execute_core.sv
hdl/aare_checker.sv
tb/sv/tb_accumulator_alu_register_execute_core.sv
